FILE: src/trle_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
// No dependencies; used by tga_rle_pixel_decoder_unit.
`default_nettype none

package trle_pkg;

    // Header bytes at or above this value open a run chunk.
    localparam logic [7:0] RUN_THRESHOLD = 8'd128;
    // A run header minus this value gives the run length.
    localparam logic [7:0] RUN_BIAS      = 8'd127;

    localparam int BPP_BITS     = 3;
    localparam int IMG_BITS     = 25;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = IMG_BITS;

    localparam logic [BPP_BITS-1:0] BPP_RESET = 3'd4;
    localparam logic [BPP_BITS-1:0] BPP_MIN   = 3'd1;
    localparam logic [BPP_BITS-1:0] BPP_MAX   = 3'd4;
    localparam logic [IMG_BITS-1:0] IMG_RESET = 25'd1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BYTES_PER_PIXEL = 1'b0,
        CFG_IMAGE_PIXELS    = 1'b1
    } t_cfg_index;

    // One decoded result as it sits in the output or skid register.
    typedef struct packed {
        logic        status;
        logic        image_done;
        logic [7:0]  repeat_count;
        logic [31:0] pixel_value;
    } t_result;

endpackage

`default_nettype wire

FILE: src/tga_rle_pixel_decoder_unit.sv
// TGA run-length decoder: one stream byte per item in, one pixel result out.
// A result is registered as its last byte is taken. Throughput: one byte per cycle
// while the skid stage is empty; a pixel result every bytes_per_pixel pixel bytes.
// A two-entry output register plus skid stage lets a byte be taken while a result waits.
// Reset (synchronous, active low) clears decode state and output valids and sets
// bytes_per_pixel to 4 and image_pixels to 1. Depends on trle_pkg.
`default_nettype none

module tga_rle_pixel_decoder_unit #(
    parameter int PIXEL_COUNT_BITS = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [trle_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [trle_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    // Input stream. tdata: [7:0] stream_byte.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,
    // Output stream. tdata: [31:0] pixel_value, [39:32] repeat_count.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,
    output logic             m_axis_tlast,   // image_done
    output logic             m_axis_tuser    // tuser: [0] status (chunk clipped)
);

    // Decoded count stays below the effective image size, which is at most
    // 2^PIXEL_COUNT_BITS and at most 2^25-1.
    localparam int CW = (PIXEL_COUNT_BITS < trle_pkg::IMG_BITS) ?
                        PIXEL_COUNT_BITS : trle_pkg::IMG_BITS;
    localparam int TW = (PIXEL_COUNT_BITS < trle_pkg::IMG_BITS) ?
                        PIXEL_COUNT_BITS + 1 : trle_pkg::IMG_BITS;
    localparam logic [25:0] CAP = (PIXEL_COUNT_BITS >= trle_pkg::IMG_BITS) ?
                                  26'h3FF_FFFF : (26'd1 << PIXEL_COUNT_BITS);

    // Configuration registers.
    logic [trle_pkg::BPP_BITS-1:0] r_bpp;
    logic [trle_pkg::IMG_BITS-1:0] r_img;

    // Decode state.
    logic          r_expect_header, n_expect_header;
    logic          r_chunk_is_run,  n_chunk_is_run;
    logic [7:0]    r_chunk_left,    n_chunk_left;
    logic [1:0]    r_byte_in_pixel, n_byte_in_pixel;
    logic [23:0]   r_assembly,      n_assembly;
    logic [CW-1:0] r_decoded,       n_decoded;

    // Output register and skid stage.
    logic                r_out_valid, r_skid_valid;
    trle_pkg::t_result   r_out, r_skid;

    logic                accept, out_take;
    logic                res_valid;
    trle_pkg::t_result   res;

    logic [2:0]    eff_bpp;
    logic [25:0]   total_wide;
    logic [TW-1:0] total, decoded_ext, remain;
    logic [7:0]    cnt_raw;
    logic          done;
    logic [31:0]   pixel;
    logic [31:0]   byte_shifted;

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_take      = r_out_valid && m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.repeat_count, r_out.pixel_value};
    assign m_axis_tlast  = r_out.image_done;
    assign m_axis_tuser  = r_out.status;

    always_comb begin
        if (r_bpp < trle_pkg::BPP_MIN) begin
            eff_bpp = trle_pkg::BPP_MIN;
        end else if (r_bpp > trle_pkg::BPP_MAX) begin
            eff_bpp = trle_pkg::BPP_MAX;
        end else begin
            eff_bpp = r_bpp;
        end
    end

    always_comb begin
        total_wide = {1'b0, r_img};
        if (r_img == '0) begin
            total_wide = 26'd1;
        end
        if (total_wide > CAP) begin
            total_wide = CAP;
        end
        total       = total_wide[TW-1:0];
        decoded_ext = TW'(r_decoded);
        // If the size was lowered below the decoded count, the next pixel ends the image.
        remain      = (total > decoded_ext) ? (total - decoded_ext) : TW'(1);
    end

    always_comb begin
        case (r_byte_in_pixel)
            2'd0:    byte_shifted = {24'd0, s_axis_tdata};
            2'd1:    byte_shifted = {16'd0, s_axis_tdata, 8'd0};
            2'd2:    byte_shifted = {8'd0, s_axis_tdata, 16'd0};
            2'd3:    byte_shifted = {s_axis_tdata, 24'd0};
            default: byte_shifted = '0;
        endcase
    end

    always_comb begin
        n_expect_header = r_expect_header;
        n_chunk_is_run  = r_chunk_is_run;
        n_chunk_left    = r_chunk_left;
        n_byte_in_pixel = r_byte_in_pixel;
        n_assembly      = r_assembly;
        n_decoded       = r_decoded;
        res_valid       = 1'b0;
        pixel           = {8'd0, r_assembly} | byte_shifted;
        cnt_raw         = r_chunk_is_run ? r_chunk_left : 8'd1;
        if (cnt_raw == 8'd0) begin
            cnt_raw = 8'd1;
        end
        done             = TW'(cnt_raw) >= remain;
        res.pixel_value  = pixel;
        res.repeat_count = done ? remain[7:0] : cnt_raw;
        res.image_done   = done;
        res.status       = done && (r_chunk_left > res.repeat_count);

        if (accept) begin
            if (r_expect_header) begin
                if (s_axis_tdata < trle_pkg::RUN_THRESHOLD) begin
                    n_chunk_is_run = 1'b0;
                    n_chunk_left   = s_axis_tdata + 8'd1;
                end else begin
                    n_chunk_is_run = 1'b1;
                    n_chunk_left   = s_axis_tdata - trle_pkg::RUN_BIAS;
                end
                n_expect_header = 1'b0;
                n_byte_in_pixel = 2'd0;
                n_assembly      = '0;
            end else if ({1'b0, r_byte_in_pixel} + 3'd1 < eff_bpp) begin
                n_assembly      = r_assembly | byte_shifted[23:0];
                n_byte_in_pixel = r_byte_in_pixel + 2'd1;
            end else begin
                res_valid       = 1'b1;
                n_byte_in_pixel = 2'd0;
                n_assembly      = '0;
                if (done) begin
                    n_decoded       = '0;
                    n_chunk_left    = 8'd0;
                    n_expect_header = 1'b1;
                end else begin
                    n_decoded    = r_decoded + CW'(cnt_raw);
                    n_chunk_left = (r_chunk_left > cnt_raw) ? (r_chunk_left - cnt_raw) : 8'd0;
                    if (n_chunk_left == 8'd0) begin
                        n_expect_header = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp           <= trle_pkg::BPP_RESET;
            r_img           <= trle_pkg::IMG_RESET;
            r_expect_header <= 1'b1;
            r_chunk_is_run  <= 1'b0;
            r_chunk_left    <= 8'd0;
            r_byte_in_pixel <= 2'd0;
            r_assembly      <= '0;
            r_decoded       <= '0;
            r_out_valid     <= 1'b0;
            r_skid_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (trle_pkg::t_cfg_index'(i_cfg_index))
                    trle_pkg::CFG_BYTES_PER_PIXEL:
                        r_bpp <= i_cfg_data[trle_pkg::BPP_BITS-1:0];
                    trle_pkg::CFG_IMAGE_PIXELS:
                        r_img <= i_cfg_data;
                    default: ;
                endcase
            end
            r_expect_header <= n_expect_header;
            r_chunk_is_run  <= n_chunk_is_run;
            r_chunk_left    <= n_chunk_left;
            r_byte_in_pixel <= n_byte_in_pixel;
            r_assembly      <= n_assembly;
            r_decoded       <= n_decoded;

            // The skid entry drains first; input is held off while it is full.
            if (r_skid_valid) begin
                if (out_take) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (res_valid) begin
                if (!r_out_valid || out_take) begin
                    r_out       <= res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= res;
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output entry");

    a_chunk_open_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_expect_header |-> (r_chunk_left != 8'd0))
        else $error("open chunk with no pixels left");

    a_repeat_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[39:32] != 8'd0))
        else $error("result with zero repeat count");

    a_clip_marks_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("clipped result that does not end the image");

    a_done_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && done) |=> (r_decoded == '0 && r_expect_header))
        else $error("image end did not restart the pixel count");

endmodule

`default_nettype wire

FILE: dv/tga_rle_pixel_decoder_unit_tb.sv
// Self-checking testbench for tga_rle_pixel_decoder_unit: directed and random byte streams,
// each accepted byte run through a local decoder model, results checked as they leave.
// Depends on trle_pkg and tga_rle_pixel_decoder_unit.
`default_nettype none

module tga_rle_pixel_decoder_unit_tb;

    localparam int COUNT_BITS = 24;
    localparam logic [trle_pkg::IMG_BITS-1:0] PIX_CAP = 25'd1 << COUNT_BITS;
    localparam int RANDOM_BYTES = 1750;
    localparam int STUCK_LIMIT = 2000;

    typedef struct packed {
        logic        hdr_wait;
        logic        run_chunk;
        logic [7:0]  chunk_left;
        logic [1:0]  byte_idx;
        logic [23:0] assembly;
        logic [24:0] decoded;
    } t_dec_state;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_we = 1'b0;
    logic [trle_pkg::CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [trle_pkg::CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [7:0]                         s_axis_tdata = '0;   // [7:0] stream_byte
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    // [31:0] pixel_value, [39:32] repeat_count
    logic [39:0]                        m_axis_tdata;
    logic                               m_axis_tlast;
    logic                               m_axis_tuser;        // [0] status

    tga_rle_pixel_decoder_unit #(
        .PIXEL_COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [trle_pkg::BPP_BITS-1:0] cfg_bpp = trle_pkg::BPP_RESET;
    logic [trle_pkg::IMG_BITS-1:0] cfg_pixels = trle_pkg::IMG_RESET;
    t_dec_state                    decoder_model = '{hdr_wait: 1'b1, default: '0};
    logic [7:0]                    stream_bytes_q[$];
    trle_pkg::t_result             expected_pixels[$];
    int unsigned                   n_pushed = 0;
    int unsigned                   n_taken = 0;
    int unsigned                   mismatches = 0;
    int unsigned                   stuck_cycles = 0;
    int unsigned                   in_gap = 0;
    int unsigned                   out_stall = 0;
    bit                            byte_sent = 1'b0;
    bit                            steady_in = 1'b0;
    bit                            steady_out = 1'b0;

    // Mostly short gaps, a few long ones; none at all while a steady stretch runs.
    function automatic int unsigned pick_gap(input bit steady);
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Decodes one stream byte; returns 1 when the byte completes a pixel result.
    function automatic bit decode_byte(inout t_dec_state st, input logic [7:0] b,
                                       output trle_pkg::t_result r);
        int unsigned bpp;
        logic [24:0] total;
        logic [24:0] remain;
        logic [24:0] cnt;
        logic [31:0] pix;
        bit          done;
        r = '0;
        if (cfg_bpp < trle_pkg::BPP_MIN) bpp = 32'(trle_pkg::BPP_MIN);
        else if (cfg_bpp > trle_pkg::BPP_MAX) bpp = 32'(trle_pkg::BPP_MAX);
        else bpp = 32'(cfg_bpp);
        if (st.hdr_wait) begin
            st.run_chunk = (b >= trle_pkg::RUN_THRESHOLD);
            st.chunk_left = st.run_chunk ? b - trle_pkg::RUN_BIAS : b + 8'd1;
            st.hdr_wait = 1'b0;
            st.byte_idx = '0;
            st.assembly = '0;
            return 1'b0;
        end
        if (st.byte_idx + 1 < bpp) begin
            st.assembly = st.assembly | (24'(b) << (8 * st.byte_idx));
            st.byte_idx = st.byte_idx + 2'd1;
            return 1'b0;
        end
        // A byte that arrives after the pixel size was lowered keeps its own position.
        pix = {8'h00, st.assembly} | (32'(b) << (8 * st.byte_idx));
        st.byte_idx = '0;
        st.assembly = '0;
        total = (cfg_pixels == '0) ? 25'd1 : (cfg_pixels > PIX_CAP) ? PIX_CAP : cfg_pixels;
        remain = (total > st.decoded) ? total - st.decoded : 25'd1;
        cnt = st.run_chunk ? 25'(st.chunk_left) : 25'd1;
        if (cnt == '0) cnt = 25'd1;
        if (cnt > remain) cnt = remain;
        done = (cnt >= remain);
        r.pixel_value = pix;
        r.repeat_count = cnt[7:0];
        r.image_done = done;
        r.status = done && (25'(st.chunk_left) > cnt);
        if (done) begin
            st.decoded = '0;
            st.chunk_left = '0;
            st.hdr_wait = 1'b1;
        end else begin
            st.decoded = st.decoded + cnt;
            st.chunk_left = (25'(st.chunk_left) > cnt) ? st.chunk_left - cnt[7:0] : 8'd0;
            if (st.chunk_left == '0) st.hdr_wait = 1'b1;
        end
        return 1'b1;
    endfunction

    // Input side: present the next queued byte once the previous one was taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || byte_sent)) begin
            if (in_gap > 0) begin
                in_gap = in_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (stream_bytes_q.size() > 0) begin
                s_axis_tdata <= stream_bytes_q.pop_front();
                s_axis_tvalid <= 1'b1;
                in_gap = pick_gap(steady_in);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output side back-pressure.
    always @(negedge i_clk) begin
        if (out_stall > 0) begin
            out_stall = out_stall - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            out_stall = pick_gap(steady_out);
        end
    end

    // Check departing results first, then predict from the byte taken at this edge.
    always @(posedge i_clk) begin : pixel_check
        trle_pkg::t_result want;
        trle_pkg::t_result got;
        byte_sent = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.pixel_value = m_axis_tdata[31:0];
            got.repeat_count = m_axis_tdata[39:32];
            got.image_done = m_axis_tlast;
            got.status = m_axis_tuser;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                $display({"%0t: unexpected result: expected none, ",
                          "actual pix=%h cnt=%0d done=%b st=%b"},
                         $time, got.pixel_value, got.repeat_count, got.image_done,
                         got.status);
            end else begin
                want = expected_pixels.pop_front();
                if (got.pixel_value !== want.pixel_value
                        || got.repeat_count !== want.repeat_count
                        || got.image_done !== want.image_done
                        || got.status !== want.status) begin
                    mismatches++;
                    $display({"%0t: expected pix=%h cnt=%0d done=%b st=%b, ",
                              "actual pix=%h cnt=%0d done=%b st=%b"},
                             $time, want.pixel_value, want.repeat_count,
                             want.image_done, want.status,
                             got.pixel_value, got.repeat_count,
                             got.image_done, got.status);
                end
            end
        end
        if (byte_sent) begin
            n_taken++;
            if (decode_byte(decoder_model, s_axis_tdata, want)) expected_pixels.push_back(want);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        stream_bytes_q.push_back(b);
        n_pushed++;
    endtask

    // Headers and partial pixels give no result, so the wait also covers every pushed byte being taken.
    task automatic wait_idle();
        do @(negedge i_clk); while (n_taken != n_pushed || expected_pixels.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input trle_pkg::t_cfg_index idx,
                             input logic [trle_pkg::CFG_DATA_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == trle_pkg::CFG_BYTES_PER_PIXEL) cfg_bpp = val[trle_pkg::BPP_BITS-1:0];
        else cfg_pixels = val[trle_pkg::IMG_BITS-1:0];
    endtask

    initial begin : stimulus
        t_dec_state        plan;
        trle_pkg::t_result unused;
        int unsigned       random_sent;
        int unsigned       budget;
        int unsigned       len;
        int unsigned       r;
        logic [2:0]        bpp_val;
        logic [24:0]       img_val;
        logic [7:0]        b;
        random_sent = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting: one 4-byte literal pixel fills the single-pixel image.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h00);
        wait_idle();

        // Longest run and longest literal chunk, both clipped to a 3-pixel image.
        write_reg(trle_pkg::CFG_BYTES_PER_PIXEL, 25'(trle_pkg::BPP_MIN));
        write_reg(trle_pkg::CFG_IMAGE_PIXELS, 25'd3);
        push_byte(8'hFF);
        push_byte(8'hAB);
        push_byte(8'h7F);
        push_byte(8'h01);
        push_byte(8'h02);
        push_byte(8'h03);
        push_byte(8'h80);
        push_byte(8'h55);
        wait_idle();

        // Image size dropped to the pixels already decoded; zero values act as one.
        write_reg(trle_pkg::CFG_BYTES_PER_PIXEL, 25'd0);
        write_reg(trle_pkg::CFG_IMAGE_PIXELS, 25'd0);
        push_byte(8'h00);
        push_byte(8'h77);
        wait_idle();

        // Oversized register values, then stop two bytes into a 4-byte pixel.
        write_reg(trle_pkg::CFG_BYTES_PER_PIXEL, 25'd7);
        write_reg(trle_pkg::CFG_IMAGE_PIXELS, 25'h1FFFFFF);
        push_byte(8'h81);
        push_byte(8'h11);
        push_byte(8'h22);
        push_byte(8'h33);
        push_byte(8'h44);
        push_byte(8'h02);
        push_byte(8'hA5);
        push_byte(8'h5A);
        wait_idle();

        // Pixel size lowered mid-pixel: the next byte closes the pixel.
        write_reg(trle_pkg::CFG_BYTES_PER_PIXEL, 25'd2);
        push_byte(8'hC3);
        wait_idle();

        while (random_sent < RANDOM_BYTES) begin
            r = $urandom_range(0, 9);
            bpp_val = (r < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
            r = $urandom_range(0, 19);
            if (r < 14) img_val = 25'($urandom_range(1, 40));
            else if (r < 17) img_val = 25'($urandom_range(41, 400));
            else begin
                case ($urandom_range(0, 4))
                    0: img_val = 25'd0;
                    1: img_val = PIX_CAP;
                    2: img_val = PIX_CAP + 25'd1;
                    3: img_val = 25'h1FFFFFF;
                    default: img_val = 25'd1;
                endcase
            end
            if ($urandom_range(0, 1) == 0) begin
                write_reg(trle_pkg::CFG_BYTES_PER_PIXEL, 25'(bpp_val));
                write_reg(trle_pkg::CFG_IMAGE_PIXELS, img_val);
            end else begin
                write_reg(trle_pkg::CFG_IMAGE_PIXELS, img_val);
                write_reg(trle_pkg::CFG_BYTES_PER_PIXEL, 25'(bpp_val));
            end
            steady_in = ($urandom_range(0, 4) == 0);
            steady_out = ($urandom_range(0, 4) == 0);

            // A planning copy of the model tells whether the next byte is read as a header.
            plan = decoder_model;
            budget = $urandom_range(60, 220);
            if (budget > RANDOM_BYTES - random_sent) budget = RANDOM_BYTES - random_sent;
            for (int unsigned k = 0; k < budget; k++) begin
                if (plan.hdr_wait && $urandom_range(0, 15) != 0) begin
                    r = $urandom_range(0, 9);
                    if (r < 6) len = $urandom_range(1, 6);
                    else if (r < 9) len = $urandom_range(7, 40);
                    else len = $urandom_range(41, 128);
                    b = ($urandom_range(0, 1) == 1) ? 8'(len + 127) : 8'(len - 1);
                end else begin
                    b = 8'($urandom_range(0, 255));
                end
                push_byte(b);
                void'(decode_byte(plan, b, unused));
            end
            random_sent += budget;
            wait_idle();
        end

        repeat (4) @(negedge i_clk);
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
